### rtl/tcct_pkg.sv
// ----------------------------------------------------------------------------
// tcct_pkg: shared types and constants of the thermal charge-current throttle
// Field widths, configuration register indexes, reset values and the
// running-sum width helper used by the pipeline stages.
// ----------------------------------------------------------------------------
package tcct_pkg;

  localparam int NUM_SENSORS   = 3;
  localparam int KELVIN_W      = 9;
  localparam int TEMP_W        = 10;
  localparam int MA_W          = 16;
  localparam int LEVEL_W       = 3;
  localparam int CNT_W         = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int KELVIN_OFFSET = 273;
  localparam int NUM_LEVELS    = 4;

  // Sensor lanes in the history word and the sum vector.
  localparam int SENSOR_CHARGER = 0;
  localparam int SENSOR_SUPPLY  = 1;
  localparam int SENSOR_AMBIENT = 2;

  // Configuration reset values.
  localparam logic [TEMP_W-1:0]     RST_CHARGER_THRESHOLD = TEMP_W'(200);
  localparam logic [CNT_W-1:0]      RST_KEEP_TIME         = CNT_W'(5);
  localparam logic [TEMP_W-1:0]     RST_AMBIENT_THRESHOLD = TEMP_W'(55);
  localparam logic [TEMP_W-1:0]     RST_CHOKE_TRIGGER     = TEMP_W'(60);
  localparam logic [TEMP_W-1:0]     RST_CHOKE_RELEASE     = TEMP_W'(55);
  // 3600 / 3000 / 2400 / 1600 mA for levels 1 to 4, level 1 in the low half-word.
  localparam logic [CFG_DATA_W-1:0] RST_LIMIT_TABLE       = 64'h0640_0960_0BB8_0E10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARGER_THRESHOLD = 3'd0,
    CFG_KEEP_TIME         = 3'd1,
    CFG_AMBIENT_THRESHOLD = 3'd2,
    CFG_CHOKE_TRIGGER     = 3'd3,
    CFG_CHOKE_RELEASE     = 3'd4,
    CFG_LIMIT_TABLE       = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    REQ_TICK   = 1'b0,
    REQ_CHARGE = 1'b1
  } req_type_e;

  // Non-temperature part of an item, carried down the pipeline.
  typedef struct packed {
    req_type_e         req_type;
    logic              discharging;
    logic              chipset_on;
    logic [MA_W-1:0]   requested_ma;
    logic              battery_responsive;
  } tcct_item_t;

  // Temperatures are two's complement, compare through $signed.
  typedef struct packed {
    logic [TEMP_W-1:0]     charger_threshold;
    logic [CNT_W-1:0]      keep_time;
    logic [TEMP_W-1:0]     ambient_threshold;
    logic [TEMP_W-1:0]     choke_trigger;
    logic [TEMP_W-1:0]     choke_release;
    logic [CFG_DATA_W-1:0] limit_table;
  } tcct_cfg_t;

  // Signed width of a running sum over a window of the given depth.
  function automatic int sum_width(input int window);
    return $clog2(window * KELVIN_OFFSET + 1) + 1;
  endfunction

endpackage

### rtl/tcct_ram.sv
// ----------------------------------------------------------------------------
// tcct_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module tcct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tcct_window.sv
// ----------------------------------------------------------------------------
// tcct_window: history ring and running sums
// On each tick, reads the oldest sample of each sensor from the history RAM,
// replaces it with the new one and updates the three running sums.
// ----------------------------------------------------------------------------
module tcct_window
  import tcct_pkg::*;
#(
  parameter int WINDOW = 60,
  parameter int SUM_W  = sum_width(WINDOW)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  tcct_item_t                           item_i,
  input  logic [NUM_SENSORS-1:0][KELVIN_W-1:0] kelvin_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output tcct_item_t                           item_o,
  output logic [NUM_SENSORS-1:0][SUM_W-1:0]    sums_o
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  logic                                 s1_valid_q;
  tcct_item_t                           s1_item_q;
  logic [NUM_SENSORS-1:0][TEMP_W-1:0]   s1_cel_q;
  logic [IDX_W-1:0]                     s1_addr_q;
  logic                                 s1_hit_q;
  logic                                 s1_fwd_q;
  logic [NUM_SENSORS-1:0][TEMP_W-1:0]   fwd_data_q;
  logic [IDX_W-1:0]                     idx_q;
  logic [WINDOW-1:0]                    hist_vld_q;
  logic                                 out_valid_q;
  tcct_item_t                           out_item_q;
  logic [NUM_SENSORS-1:0][SUM_W-1:0]    sum_q;
  logic [NUM_SENSORS-1:0][SUM_W-1:0]    sum_d;
  logic [NUM_SENSORS-1:0][TEMP_W-1:0]   cel_in;
  logic [NUM_SENSORS-1:0][TEMP_W-1:0]   old_cel;
  logic [NUM_SENSORS-1:0][TEMP_W-1:0]   ram_rdata;
  logic                                 s1_tick;
  logic                                 advance;
  logic                                 accept;
  logic                                 rd_en;
  logic                                 wr_en;

  assign s1_tick    = (s1_item_q.req_type == REQ_TICK);
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign rd_en      = accept && (item_i.req_type == REQ_TICK);
  assign wr_en      = advance && s1_tick;

  always_comb begin
    for (int s = 0; s < NUM_SENSORS; s++) begin
      cel_in[s] = TEMP_W'(kelvin_i[s]) - TEMP_W'(KELVIN_OFFSET);
    end
  end

  // Never-written entries read as zero; a write to the entry being read in
  // the same cycle is taken from the forward register.
  assign old_cel = s1_fwd_q ? fwd_data_q : (s1_hit_q ? ram_rdata : '0);

  always_comb begin
    for (int s = 0; s < NUM_SENSORS; s++) begin
      sum_d[s] = sum_q[s] + SUM_W'($signed(s1_cel_q[s]))
               - SUM_W'($signed(old_cel[s]));
    end
  end

  tcct_ram #(
    .WIDTH (NUM_SENSORS * TEMP_W),
    .DEPTH (WINDOW),
    .ADDR_W(IDX_W)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_addr_q),
    .wdata_i(s1_cel_q),
    .re_i   (rd_en),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      hist_vld_q  <= '0;
      sum_q       <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (rd_en) begin
        idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
      end
      if (wr_en) begin
        hist_vld_q[s1_addr_q] <= 1'b1;
        sum_q                 <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q  <= item_i;
      s1_cel_q   <= cel_in;
      s1_addr_q  <= idx_q;
      s1_hit_q   <= hist_vld_q[idx_q];
      s1_fwd_q   <= wr_en && (s1_addr_q == idx_q);
      fwd_data_q <= s1_cel_q;
    end
    if (advance) begin
      out_item_q <= s1_item_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign item_o      = out_item_q;
  // The sums change only when a tick enters this output register.
  assign sums_o      = sum_q;

endmodule

### rtl/tcct_avg.sv
// ----------------------------------------------------------------------------
// tcct_avg: windowed averages
// Divides each running sum by the window depth, truncating toward zero,
// by an exact reciprocal multiply on the magnitude.
// ----------------------------------------------------------------------------
module tcct_avg
  import tcct_pkg::*;
#(
  parameter int WINDOW = 60,
  parameter int SUM_W  = sum_width(WINDOW)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tcct_item_t                         item_i,
  input  logic [NUM_SENSORS-1:0][SUM_W-1:0]  sums_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tcct_item_t                         item_o,
  output logic [NUM_SENSORS-1:0][TEMP_W-1:0] avgs_o
);

  localparam int MAG_W   = SUM_W - 1;
  localparam int SHIFT   = MAG_W + $clog2(WINDOW);
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int QUO_W   = TEMP_W - 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SHIFT + WINDOW - 1) / WINDOW);

  logic                               valid_q;
  tcct_item_t                         item_q;
  logic [NUM_SENSORS-1:0][TEMP_W-1:0] avg_q;
  logic [NUM_SENSORS-1:0][TEMP_W-1:0] avg_d;
  logic [SUM_W-1:0]                   neg_sum;
  logic [MAG_W-1:0]                   mag;
  logic [PROD_W-1:0]                  prod;
  logic [QUO_W-1:0]                   quo;
  logic                               neg;
  logic                               accept;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    neg_sum = '0;
    mag     = '0;
    prod    = '0;
    quo     = '0;
    neg     = 1'b0;
    for (int s = 0; s < NUM_SENSORS; s++) begin
      neg      = sums_i[s][SUM_W-1];
      neg_sum  = -sums_i[s];
      mag      = neg ? neg_sum[MAG_W-1:0] : sums_i[s][MAG_W-1:0];
      prod     = PROD_W'(mag) * PROD_W'(RECIP);
      quo      = prod[SHIFT +: QUO_W];
      avg_d[s] = neg ? -TEMP_W'(quo) : TEMP_W'(quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
      avg_q  <= avg_d;
    end
  end

  assign out_valid_o = valid_q;
  assign item_o      = item_q;
  assign avgs_o      = avg_q;

endmodule

### rtl/tcct_policy.sv
// ----------------------------------------------------------------------------
// tcct_policy: throttle level, USB-A enable and current clamp
// Applies the dwell-qualified level and USB-A rules on ticks, clamps charge
// requests, and holds the result register.
// ----------------------------------------------------------------------------
module tcct_policy
  import tcct_pkg::*;
(
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tcct_cfg_t                          cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tcct_item_t                         item_i,
  input  logic [NUM_SENSORS-1:0][TEMP_W-1:0] avgs_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [LEVEL_W-1:0]                 throttle_level_o,
  output logic                               usba_enabled_o,
  output logic [NUM_SENSORS-1:0][TEMP_W-1:0] avgs_o,
  output logic [MA_W-1:0]                    granted_ma_o
);

  typedef struct packed {
    logic             fire;
    logic [CNT_W-1:0] cnt;
  } dwell_t;

  function automatic dwell_t dwell(input logic [CNT_W-1:0] cnt,
                                   input logic [CNT_W-1:0] keep);
    dwell_t r;
    r.fire = (cnt >= keep);
    r.cnt  = r.fire ? '0 : cnt + 1'b1;
    return r;
  endfunction

  localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(NUM_LEVELS);

  logic [LEVEL_W-1:0]                 level_q, level_d;
  logic [CNT_W-1:0]                   lvl_up_q, lvl_up_d;
  logic [CNT_W-1:0]                   lvl_dn_q, lvl_dn_d;
  logic [CNT_W-1:0]                   usb_up_q, usb_up_d;
  logic [CNT_W-1:0]                   usb_dn_q, usb_dn_d;
  logic                               usba_q, usba_d;
  logic [NUM_SENSORS-1:0][TEMP_W-1:0] avg_q, avg_d;
  logic                               valid_q;
  logic [MA_W-1:0]                    granted_q, granted_d;
  logic [MA_W-1:0]                    limit;
  logic                               tick;
  logic                               accept;
  logic signed [TEMP_W-1:0]           chg_avg;
  logic signed [TEMP_W-1:0]           amb_avg;
  dwell_t                             dw;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tick       = (item_i.req_type == REQ_TICK);
  assign chg_avg    = $signed(avgs_i[SENSOR_CHARGER]);
  assign amb_avg    = $signed(avgs_i[SENSOR_AMBIENT]);

  always_comb begin
    level_d  = level_q;
    lvl_up_d = lvl_up_q;
    lvl_dn_d = lvl_dn_q;
    usb_up_d = usb_up_q;
    usb_dn_d = usb_dn_q;
    usba_d   = usba_q;
    avg_d    = avg_q;
    dw       = '0;
    if (tick) begin
      avg_d = avgs_i;
      // Throttle level.
      if (item_i.discharging) begin
        level_d  = '0;
        lvl_up_d = '0;
        lvl_dn_d = '0;
      end else if (chg_avg >= $signed(cfg_i.charger_threshold)) begin
        lvl_dn_d = '0;
        dw       = dwell(lvl_up_q, cfg_i.keep_time);
        lvl_up_d = dw.cnt;
        if (dw.fire && level_q < MAX_LEVEL) begin
          level_d = level_q + 1'b1;
        end
      end else if (level_q != '0) begin
        lvl_up_d = '0;
        dw       = dwell(lvl_dn_q, cfg_i.keep_time);
        lvl_dn_d = dw.cnt;
        if (dw.fire) begin
          level_d = level_q - 1'b1;
        end
      end else begin
        lvl_up_d = '0;
        lvl_dn_d = '0;
      end
      // USB-A enable; release is tested before trigger.
      if (!item_i.chipset_on || amb_avg >= $signed(cfg_i.ambient_threshold)) begin
        usb_up_d = '0;
        usb_dn_d = '0;
        usba_d   = 1'b1;
      end else if (chg_avg < $signed(cfg_i.choke_release)) begin
        usb_up_d = '0;
        dw       = dwell(usb_dn_q, cfg_i.keep_time);
        usb_dn_d = dw.cnt;
        if (dw.fire) begin
          usba_d = 1'b1;
        end
      end else if (chg_avg >= $signed(cfg_i.choke_trigger)) begin
        usb_dn_d = '0;
        dw       = dwell(usb_up_q, cfg_i.keep_time);
        usb_up_d = dw.cnt;
        if (dw.fire) begin
          usba_d = 1'b0;
        end
      end else begin
        usb_up_d = '0;
        usb_dn_d = '0;
      end
    end
  end

  always_comb begin
    unique case (level_q)
      3'd1:    limit = cfg_i.limit_table[15:0];
      3'd2:    limit = cfg_i.limit_table[31:16];
      3'd3:    limit = cfg_i.limit_table[47:32];
      3'd4:    limit = cfg_i.limit_table[63:48];
      default: limit = '1;
    endcase
    granted_d = '0;
    if (!tick) begin
      granted_d = item_i.requested_ma;
      if (item_i.battery_responsive && level_q != '0 && item_i.requested_ma > limit) begin
        granted_d = limit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      level_q  <= '0;
      lvl_up_q <= '0;
      lvl_dn_q <= '0;
      usb_up_q <= '0;
      usb_dn_q <= '0;
      usba_q   <= 1'b1;
      avg_q    <= '0;
    end else begin
      if (accept) begin
        valid_q  <= 1'b1;
        level_q  <= level_d;
        lvl_up_q <= lvl_up_d;
        lvl_dn_q <= lvl_dn_d;
        usb_up_q <= usb_up_d;
        usb_dn_q <= usb_dn_d;
        usba_q   <= usba_d;
        avg_q    <= avg_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      granted_q <= granted_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign throttle_level_o = level_q;
  assign usba_enabled_o   = usba_q;
  assign avgs_o           = avg_q;
  assign granted_ma_o     = granted_q;

endmodule

### rtl/thermal_charge_current_throttle.sv
// ----------------------------------------------------------------------------
// thermal_charge_current_throttle: thermal charge-current throttle
// Windowed temperature averages, throttle level, USB-A enable and current
// clamp behind valid/ready channels and a plain register write port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one transfer per item. A tick (req_type 0) brings three
//   Kelvin samples plus the discharging and chipset_on flags; a charge
//   request (req_type 1) brings requested_ma and battery_responsive.
//   Output channel: exactly one result transfer per item, in order, showing
//   the level, USB-A enable and averages after the item; granted_ma is the
//   clamped current on requests and 0 on ticks.
//   Order: each item passes the history read, sum update, reciprocal
//   multiply and policy/result registers in turn; a stall holds it in place.
//   Throughput: one item per cycle unless stalled. The only shared resource
//   is the history RAM, read once when a tick is taken and written once when
//   it leaves the read stage; a write to the entry being read is forwarded.
//   Stall: when out_ready_i is low each stage holds its item; upstream stages
//   keep filling empty slots, so up to four items are in flight before
//   in_ready_o drops.
//   Reset: averages, sums, level, dwell counters clear and USB-A is enabled;
//   per-entry valid bits make the whole history read as zero, so no clearing
//   pass is needed. Configuration returns to its defaults. Write registers
//   only while no item is in flight.
// ----------------------------------------------------------------------------
module thermal_charge_current_throttle
  import tcct_pkg::*;
#(
  parameter int WINDOW = 60
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Item input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [KELVIN_W-1:0]   charger_kelvin_i,
  input  logic [KELVIN_W-1:0]   supply_kelvin_i,
  input  logic [KELVIN_W-1:0]   ambient_kelvin_i,
  input  logic                  discharging_i,
  input  logic                  chipset_on_i,
  input  logic [MA_W-1:0]       requested_ma_i,
  input  logic                  battery_responsive_i,
  // Result output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [LEVEL_W-1:0]    throttle_level_o,
  output logic                  usba_enabled_o,
  output logic [TEMP_W-1:0]     charger_avg_c_o,
  output logic [TEMP_W-1:0]     supply_avg_c_o,
  output logic [TEMP_W-1:0]     ambient_avg_c_o,
  output logic [MA_W-1:0]       granted_ma_o,
  // Register writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SUM_W = sum_width(WINDOW);

  tcct_cfg_t                          cfg_q;
  tcct_item_t                         in_item;
  logic [NUM_SENSORS-1:0][KELVIN_W-1:0] in_kelvin;

  // Window stage to average stage
  logic                               win_valid;
  logic                               win_ready;
  tcct_item_t                         win_item;
  logic [NUM_SENSORS-1:0][SUM_W-1:0]  win_sums;
  // Average stage to policy stage
  logic                               avg_valid;
  logic                               avg_ready;
  tcct_item_t                         avg_item;
  logic [NUM_SENSORS-1:0][TEMP_W-1:0] avg_vals;
  logic [NUM_SENSORS-1:0][TEMP_W-1:0] res_avgs;

  // Pack the item; sensor lanes follow the package's lane numbering.
  always_comb begin
    in_item.req_type           = req_type_e'(req_type_i);
    in_item.discharging        = discharging_i;
    in_item.chipset_on         = chipset_on_i;
    in_item.requested_ma       = requested_ma_i;
    in_item.battery_responsive = battery_responsive_i;
    in_kelvin[SENSOR_CHARGER]  = charger_kelvin_i;
    in_kelvin[SENSOR_SUPPLY]   = supply_kelvin_i;
    in_kelvin[SENSOR_AMBIENT]  = ambient_kelvin_i;
  end

  // Register file; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.charger_threshold <= RST_CHARGER_THRESHOLD;
      cfg_q.keep_time         <= RST_KEEP_TIME;
      cfg_q.ambient_threshold <= RST_AMBIENT_THRESHOLD;
      cfg_q.choke_trigger     <= RST_CHOKE_TRIGGER;
      cfg_q.choke_release     <= RST_CHOKE_RELEASE;
      cfg_q.limit_table       <= RST_LIMIT_TABLE;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CHARGER_THRESHOLD: cfg_q.charger_threshold <= cfg_data_i[TEMP_W-1:0];
        CFG_KEEP_TIME:         cfg_q.keep_time         <= cfg_data_i[CNT_W-1:0];
        CFG_AMBIENT_THRESHOLD: cfg_q.ambient_threshold <= cfg_data_i[TEMP_W-1:0];
        CFG_CHOKE_TRIGGER:     cfg_q.choke_trigger     <= cfg_data_i[TEMP_W-1:0];
        CFG_CHOKE_RELEASE:     cfg_q.choke_release     <= cfg_data_i[TEMP_W-1:0];
        CFG_LIMIT_TABLE:       cfg_q.limit_table       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // History ring and running sums.
  tcct_window #(
    .WINDOW(WINDOW),
    .SUM_W (SUM_W)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .kelvin_i   (in_kelvin),
    .out_valid_o(win_valid),
    .out_ready_i(win_ready),
    .item_o     (win_item),
    .sums_o     (win_sums)
  );

  // Sum / WINDOW, truncated toward zero.
  tcct_avg #(
    .WINDOW(WINDOW),
    .SUM_W (SUM_W)
  ) u_avg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (win_valid),
    .in_ready_o (win_ready),
    .item_i     (win_item),
    .sums_i     (win_sums),
    .out_valid_o(avg_valid),
    .out_ready_i(avg_ready),
    .item_o     (avg_item),
    .avgs_o     (avg_vals)
  );

  // Level, USB-A and clamp; owns the result register.
  tcct_policy u_policy (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (avg_valid),
    .in_ready_o      (avg_ready),
    .item_i          (avg_item),
    .avgs_i          (avg_vals),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .throttle_level_o(throttle_level_o),
    .usba_enabled_o  (usba_enabled_o),
    .avgs_o          (res_avgs),
    .granted_ma_o    (granted_ma_o)
  );

  assign charger_avg_c_o = res_avgs[SENSOR_CHARGER];
  assign supply_avg_c_o  = res_avgs[SENSOR_SUPPLY];
  assign ambient_avg_c_o = res_avgs[SENSOR_AMBIENT];

endmodule
